// ----- rtl/qxpv_pkg.sv -----
`default_nettype none

package qxpv_pkg;

  localparam int unsigned DivW = 51;
  localparam int unsigned CntW = 6;

  localparam logic [1:0] REQ_EDGE_A = 2'd0;
  localparam logic [1:0] REQ_EDGE_B = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] REG_PULSES_PER_REV = 2'd0;
  localparam logic [1:0] REG_WINDOW_MS      = 2'd1;
  localparam logic [1:0] REG_SMOOTH_ALPHA   = 2'd2;

  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  localparam logic [15:0] PPR_RESET    = 16'd1024;
  localparam logic [15:0] WINDOW_RESET = 16'd100;
  localparam logic [15:0] ALPHA_RESET  = 16'd52429;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic edge_upd;
    logic tick_cap;
    logic win_upd;
    logic raw_zero;
    logic pps_start;
    logic deg_start;
    logic raw_load;
    logic mul;
    logic add;
    logic smooth_load;
    logic out_load;
  } qxpv_cmd_t;

  typedef struct packed {
    logic elapsed_ge;
    logic start_zero;
    logic elapsed_zero;
    logic div_busy;
  } qxpv_stat_t;

endpackage

`default_nettype wire

// ----- rtl/quadrature_x2_position_velocity_unit.sv -----
`default_nettype none
// Items: an edge item is taken while idle and gives no result. A tick item gives its result
// from the check state while the window is open, after the smoothing multiply, add and load
// when the window only starts or no time has passed, and after two runs of the shared
// one-bit-per-cycle divider (51 steps each) plus smoothing when the velocity is recomputed.
// Throughput: one item at a time, taken the cycle after the result is loaded; a held result
// delays that load. Synchronous active-high reset clears control, settings and counters.

module quadrature_x2_position_velocity_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic               other_phase,
  input  wire logic [31:0]        now_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              direction,
  output logic [30:0]             speed_deg_per_s,
  output logic signed [31:0]      position
);
  import qxpv_pkg::*;

  qxpv_cmd_t  cmd;
  qxpv_stat_t stat;

  qxpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  qxpv_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .other_phase     (other_phase),
    .now_ms          (now_ms),
    .cmd             (cmd),
    .stat            (stat),
    .direction       (direction),
    .speed_deg_per_s (speed_deg_per_s),
    .position        (position)
  );

endmodule

`default_nettype wire

// ----- rtl/qxpv_div.sv -----
`default_nettype none

module qxpv_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [qxpv_pkg::DivW-1:0]  dividend,
  input  wire logic [31:0]                divisor,
  output logic                            busy,
  output logic [qxpv_pkg::DivW-1:0]       quotient
);
  import qxpv_pkg::*;

  logic [CntW-1:0] cnt;
  logic [32:0]     rem;
  logic [31:0]     dvs;
  logic [DivW-1:0] dq;
  logic [32:0]     rem_sh;
  logic            fits;

  assign rem_sh   = {rem[31:0], dq[DivW-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(DivW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      dq  <= {dq[DivW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qxpv_dp.sv -----
`default_nettype none

module qxpv_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic [1:0]           req_type,
  input  wire logic                 other_phase,
  input  wire logic [31:0]          now_ms,
  input  wire qxpv_pkg::qxpv_cmd_t  cmd,
  output qxpv_pkg::qxpv_stat_t      stat,
  output logic [1:0]                direction,
  output logic [30:0]               speed_deg_per_s,
  output logic signed [31:0]        position
);
  import qxpv_pkg::*;

  logic [15:0]        pulses_per_rev;
  logic [15:0]        window_ms;
  logic [15:0]        smooth_alpha;
  logic [31:0]        position_count;
  logic [1:0]         last_direction;
  logic [31:0]        pulses_in_window;
  logic [31:0]        window_start_ms;
  logic [31:0]        now_reg;
  logic signed [31:0] raw_velocity;
  logic signed [31:0] filt_velocity;
  logic signed [49:0] prod_old;
  logic signed [49:0] prod_new;
  logic signed [49:0] acc;

  logic               fwd;
  logic [31:0]        elapsed;
  logic               div_start;
  logic [DivW-1:0]    div_dividend;
  logic [31:0]        div_divisor;
  logic               div_busy;
  logic [DivW-1:0]    div_quotient;
  logic [30:0]        deg_sat;
  logic signed [17:0] w_old;
  logic signed [17:0] w_new;
  logic signed [49:0] acc_shift;
  logic signed [49:0] acc_trunc;
  logic [15:0]        ppr_eff;

  assign fwd     = (req_type == REQ_EDGE_A) ? !other_phase : other_phase;
  assign elapsed = now_reg - window_start_ms;
  assign ppr_eff = (pulses_per_rev == 16'd0) ? 16'd1 : pulses_per_rev;

  assign stat.elapsed_ge   = elapsed >= {16'd0, window_ms};
  assign stat.start_zero   = window_start_ms == 32'd0;
  assign stat.elapsed_zero = elapsed == 32'd0;
  assign stat.div_busy     = div_busy;

  always_comb begin
    div_start    = cmd.pps_start || cmd.deg_start;
    div_dividend = div_quotient * DivW'(360);
    div_divisor  = {16'd0, ppr_eff};
    if (cmd.pps_start) begin
      div_dividend = DivW'(pulses_in_window) * DivW'(1000);
      div_divisor  = elapsed;
    end
  end

  qxpv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assign deg_sat   = (div_quotient > DivW'(SAT31)) ? SAT31 : div_quotient[30:0];
  assign w_old     = {2'b00, smooth_alpha};
  assign w_new     = 18'sd65536 - w_old;
  assign acc_shift = acc >>> 16;
  assign acc_trunc = (acc[49] && (acc[15:0] != 16'd0)) ? acc_shift + 50'sd1 : acc_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_rev    <= PPR_RESET;
      window_ms         <= WINDOW_RESET;
      smooth_alpha      <= ALPHA_RESET;
      position_count    <= '0;
      last_direction    <= DIR_NONE;
      pulses_in_window  <= '0;
      window_start_ms   <= '0;
      raw_velocity      <= '0;
      filt_velocity     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PULSES_PER_REV: pulses_per_rev <= cfg_data;
          REG_WINDOW_MS:      window_ms      <= cfg_data;
          REG_SMOOTH_ALPHA:   smooth_alpha   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.edge_upd) begin
        position_count   <= fwd ? position_count + 32'd1 : position_count - 32'd1;
        last_direction   <= fwd ? DIR_FORWARD : DIR_REVERSE;
        pulses_in_window <= pulses_in_window + 32'd1;
      end
      if (cmd.pps_start) begin
        pulses_in_window <= '0;
      end
      if (cmd.win_upd) begin
        window_start_ms <= now_reg;
      end
      if (cmd.raw_zero) begin
        raw_velocity <= '0;
      end
      if (cmd.raw_load) begin
        raw_velocity <= (last_direction == DIR_REVERSE) ? -$signed({1'b0, deg_sat})
                                                        : $signed({1'b0, deg_sat});
      end
      if (cmd.smooth_load) begin
        filt_velocity <= acc_trunc[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_cap) begin
      now_reg <= now_ms;
    end
    if (cmd.mul) begin
      prod_old <= w_old * filt_velocity;
      prod_new <= w_new * raw_velocity;
    end
    if (cmd.add) begin
      acc <= prod_old + prod_new;
    end
    if (cmd.out_load) begin
      direction       <= last_direction;
      speed_deg_per_s <= filt_velocity[31] ? 31'(-filt_velocity)
                                           : filt_velocity[30:0];
      position        <= position_count;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qxpv_ctrl.sv -----
`default_nettype none

module qxpv_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           req_type,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire qxpv_pkg::qxpv_stat_t stat,
  output qxpv_pkg::qxpv_cmd_t       cmd
);
  import qxpv_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV1   = 3'd2;
  localparam logic [2:0] ST_DIV2   = 3'd3;
  localparam logic [2:0] ST_SMUL   = 3'd4;
  localparam logic [2:0] ST_SADD   = 3'd5;
  localparam logic [2:0] ST_SDIV   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_EDGE_A || req_type == REQ_EDGE_B) begin
            cmd.edge_upd = 1'b1;
          end else if (req_type == REQ_TICK) begin
            cmd.tick_cap = 1'b1;
            state_next   = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!stat.elapsed_ge) begin
          state_next = ST_FINISH;
        end else if (stat.start_zero || stat.elapsed_zero) begin
          cmd.win_upd  = 1'b1;
          cmd.raw_zero = 1'b1;
          state_next   = ST_SMUL;
        end else begin
          cmd.win_upd   = 1'b1;
          cmd.pps_start = 1'b1;
          state_next    = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (!stat.div_busy) begin
          cmd.deg_start = 1'b1;
          state_next    = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (!stat.div_busy) begin
          cmd.raw_load = 1'b1;
          state_next   = ST_SMUL;
        end
      end
      ST_SMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SADD;
      end
      ST_SADD: begin
        cmd.add    = 1'b1;
        state_next = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.smooth_load = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_rose_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result appeared without a finished tick");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !stat.div_busy)
    else $error("divider busy while controller is idle");

  a_div_started: assert property (@(posedge clk) disable iff (rst)
    (cmd.pps_start || cmd.deg_start) |=> stat.div_busy)
    else $error("divider did not start");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");

endmodule

`default_nettype wire

// ----- dv/quadrature_x2_position_velocity_checker.sv -----
`default_nettype none

module quadrature_x2_position_velocity_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic        other_phase,
  input  wire logic [31:0] now_ms,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  direction,
  input  wire logic [30:0] speed_deg_per_s,
  input  wire logic [31:0] position,
  output int               errors,
  output int               pending
);
  import qxpv_pkg::*;

  localparam longint SatMag = 64'sd2147483647;

  typedef struct {
    logic [1:0]  dir;
    logic [30:0] speed;
    logic [31:0] pos;
  } report_t;

  report_t reports_due[$];

  logic [15:0]        ppr;
  logic [15:0]        window_len;
  logic [15:0]        alpha;
  logic [31:0]        pos_cnt;
  logic [1:0]         last_dir;
  logic [31:0]        pulse_cnt;
  logic [31:0]        win_start;
  logic signed [31:0] raw_vel;
  logic signed [31:0] smooth_vel;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic longint clamp31(input longint v);
    if (v > SatMag) return SatMag;
    if (v < -SatMag) return -SatMag;
    return v;
  endfunction

  task automatic predict_edge(input logic [1:0] kind, input logic lvl);
    logic fwd;
    fwd = (kind == REQ_EDGE_A) ? !lvl : lvl;
    if (fwd) begin
      pos_cnt = pos_cnt + 32'd1;
      last_dir = DIR_FORWARD;
    end else begin
      pos_cnt = pos_cnt - 32'd1;
      last_dir = DIR_REVERSE;
    end
    pulse_cnt = pulse_cnt + 32'd1;
  endtask

  task automatic predict_tick(input logic [31:0] stamp);
    logic [31:0]     elapsed;
    longint unsigned per_sec;
    longint unsigned degrees;
    longint          vel;
    longint          acc;
    longint          weight;
    longint          mag;
    report_t         r;
    elapsed = stamp - win_start;
    if (elapsed >= {16'd0, window_len}) begin
      vel = 0;
      // A window that has not started yet only starts here and keeps its pulses.
      if (win_start != 32'd0 && elapsed != 32'd0) begin
        per_sec = {32'd0, pulse_cnt} * 64'd1000 / {32'd0, elapsed};
        pulse_cnt = 32'd0;
        degrees = per_sec * 64'd360 / {48'd0, (ppr == 16'd0) ? 16'd1 : ppr};
        if (degrees > SatMag) degrees = SatMag;
        vel = longint'(degrees);
        if (last_dir == DIR_REVERSE) vel = -vel;
      end
      raw_vel = vel[31:0];
      weight = {48'd0, alpha};
      acc = weight * longint'(smooth_vel) + (64'sd65536 - weight) * longint'(raw_vel);
      acc = clamp31(acc / 64'sd65536);
      smooth_vel = acc[31:0];
      win_start = stamp;
    end
    mag = longint'(smooth_vel);
    if (mag < 0) mag = -mag;
    mag = clamp31(mag);
    r.dir = last_dir;
    r.speed = mag[30:0];
    r.pos = pos_cnt;
    reports_due.push_back(r);
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      ppr = PPR_RESET;
      window_len = WINDOW_RESET;
      alpha = ALPHA_RESET;
      pos_cnt = 32'd0;
      last_dir = DIR_NONE;
      pulse_cnt = 32'd0;
      win_start = 32'd0;
      raw_vel = 32'sd0;
      smooth_vel = 32'sd0;
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result dir %0d speed %0d pos %0d", $time,
                   direction, speed_deg_per_s, $signed(position));
        end else begin
          want = reports_due.pop_front();
          if (direction !== want.dir) begin
            errors++;
            $display("%0t: direction expected %0d, actual %0d", $time, want.dir,
                     direction);
          end
          if (speed_deg_per_s !== want.speed) begin
            errors++;
            $display("%0t: speed expected %0d, actual %0d", $time, want.speed,
                     speed_deg_per_s);
          end
          if (position !== want.pos) begin
            errors++;
            $display("%0t: position expected %0d, actual %0d", $time,
                     $signed(want.pos), $signed(position));
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PULSES_PER_REV: ppr = cfg_data;
          REG_WINDOW_MS:      window_len = cfg_data;
          REG_SMOOTH_ALPHA:   alpha = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_EDGE_A || req_type == REQ_EDGE_B) begin
          predict_edge(req_type, other_phase);
        end else if (req_type == REQ_TICK) begin
          predict_tick(now_ms);
        end
      end
    end
    pending = reports_due.size();
  end

endmodule

`default_nettype wire

// ----- dv/quadrature_x2_position_velocity_unit_test.sv -----
`default_nettype none

module quadrature_x2_position_velocity_unit_test;
  import qxpv_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam logic [1:0] ReqUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_PULSES_PER_REV;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic [1:0]  req_type = REQ_EDGE_A;
  logic        other_phase = 1'b0;
  logic [31:0] now_ms = 32'd0;
  logic        out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [1:0]         direction;
  logic [30:0]        speed_deg_per_s;
  logic signed [31:0] position;

  int          errors;
  int          pending;
  logic        calm = 1'b0;
  logic [31:0] t_ms = 32'd0;
  logic [15:0] cur_window = WINDOW_RESET;
  int unsigned cycles = 0;

  quadrature_x2_position_velocity_unit dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .other_phase     (other_phase),
    .now_ms          (now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .direction       (direction),
    .speed_deg_per_s (speed_deg_per_s),
    .position        (position)
  );

  quadrature_x2_position_velocity_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .other_phase     (other_phase),
    .now_ms          (now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .direction       (direction),
    .speed_deg_per_s (speed_deg_per_s),
    .position        (position),
    .errors          (errors),
    .pending         (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 18);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("quadrature_x2_position_velocity_unit verification failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] kind, input logic lvl, input logic [31:0] stamp);
    int gap;
    if (!calm && $urandom_range(0, 99) < 18) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    other_phase <= lvl;
    now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] ppr, input logic [15:0] win,
                           input logic [15:0] alpha);
    cfg_write <= 1'b1;
    cfg_index <= REG_PULSES_PER_REV;
    cfg_data <= ppr;
    @(posedge clk);
    cfg_index <= REG_WINDOW_MS;
    cfg_data <= win;
    @(posedge clk);
    cfg_index <= REG_SMOOTH_ALPHA;
    cfg_data <= alpha;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_window = win;
  endtask

  task automatic spin_edge(input logic fwd);
    logic [1:0] kind;
    kind = $urandom_range(0, 1) ? REQ_EDGE_B : REQ_EDGE_A;
    send(kind, (kind == REQ_EDGE_B) ? fwd : !fwd, $urandom());
  endtask

  // One window of motion: a burst of edges followed by a tick, or a stray item.
  task automatic random_window(inout int budget);
    int          pick;
    int          burst;
    logic        fwd;
    logic [31:0] step;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send(($urandom_range(0, 1) != 0) ? ReqUnused : 2'($urandom_range(0, 2)),
           1'($urandom_range(0, 1)), $urandom());
      budget--;
    end else begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      fwd = 1'($urandom_range(0, 1));
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) fwd = !fwd;
        spin_edge(fwd);
        budget--;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) step = 32'd0;
      else if (pick < 35) step = $urandom_range(0, cur_window);
      else if (pick < 85) step = cur_window + $urandom_range(0, cur_window + 20);
      else if (pick < 95) step = $urandom();
      else step = -t_ms;
      t_ms = t_ms + step;
      send(REQ_TICK, 1'($urandom_range(0, 1)), t_ms);
      budget--;
    end
  endtask

  initial begin
    int budget;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(ReqUnused, 1'b1, 32'hFFFF_FFFF);
    send(REQ_TICK, 1'b0, 32'd0);
    send(REQ_EDGE_A, 1'b0, 32'd0);
    send(REQ_EDGE_A, 1'b1, 32'd0);
    send(REQ_EDGE_B, 1'b1, 32'd0);
    send(REQ_EDGE_B, 1'b0, 32'd0);
    repeat (3) send(REQ_EDGE_A, 1'b0, 32'hFFFF_FFFF);
    send(REQ_TICK, 1'b1, 32'd100);
    repeat (2) send(REQ_EDGE_B, 1'b1, 32'd0);
    send(REQ_TICK, 1'b0, 32'd150);
    send(REQ_TICK, 1'b0, 32'd200);
    repeat (2) send(REQ_EDGE_A, 1'b1, 32'd0);
    send(REQ_TICK, 1'b0, 32'hFFFF_FF00);
    // Recomputing at time zero leaves the window marked as not started.
    send(REQ_TICK, 1'b0, 32'd0);
    send(REQ_EDGE_B, 1'b0, 32'd0);
    send(REQ_TICK, 1'b0, 32'd300);
    send(REQ_TICK, 1'b0, 32'd400);
    drain();

    // Hundreds of pulses in a one-millisecond window give a very high speed.
    configure(16'd1, 16'd1, 16'd0);
    send(REQ_TICK, 1'b0, 32'd1000);
    repeat (200) send(REQ_EDGE_A, 1'b0, $urandom());
    send(REQ_TICK, 1'b0, 32'd1001);
    repeat (200) send(REQ_EDGE_B, 1'b0, $urandom());
    send(REQ_TICK, 1'b0, 32'd1002);
    t_ms = 32'd1002;

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: configure(16'd65535, 16'd65535, 16'd65535);
        2: configure(16'd0, 16'd0, 16'($urandom()));
        3: configure(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 300)),
                     16'($urandom()));
        4: configure(PPR_RESET, WINDOW_RESET, ALPHA_RESET);
        default: ;
      endcase
      calm = (phase == 3);
      budget = 175;
      while (budget > 0) random_window(budget);
      drain();
    end

    if (errors == 0) begin
      $display("quadrature_x2_position_velocity_unit verification clean");
    end else begin
      $display("quadrature_x2_position_velocity_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
